FILE: src/avcd_pkg.sv
`default_nettype none
package avcd_pkg;

	localparam int FRAC_BITS = 10;
	localparam int SHW = 32 + FRAC_BITS;
	localparam int SPL = SHW / 2;
	localparam int QW = 26;
	localparam int HDR_LEN = 30;
	localparam logic [2:0] HDR_SKIP = 3'd7;
	localparam logic [9:0] RATE_SCALE = 10'd830;
	localparam logic [7:0] VERSION_OK = 8'd7;
	localparam logic [31:0] PLAYER_MAX = 32'd213;
	localparam logic [9:0] ROUND_ADD = 10'd512;
	localparam logic [SHW-1:0] SHARE_MIN = SHW'(1) << (FRAC_BITS - 1);

	localparam logic [2:0] K_HDR = 3'd0;
	localparam logic [2:0] K_SIZE = 3'd1;
	localparam logic [2:0] K_PAY = 3'd2;
	localparam logic [2:0] K_ANN = 3'd3;
	localparam logic [2:0] K_SUM = 3'd4;
	localparam logic [2:0] K_ERR = 3'd5;
	localparam logic [2:0] K_DISC = 3'd6;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_ZERO = 3'd1;
	localparam logic [2:0] ST_VERSION = 3'd2;
	localparam logic [2:0] ST_SHARE = 3'd3;
	localparam logic [2:0] ST_EXHAUST = 3'd4;

	localparam logic [2:0] HDR_FIELD [HDR_LEN] = '{
		3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2,
		3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd7, 3'd4, 3'd4, 3'd5, 3'd5,
		3'd5, 3'd5, 3'd7, 3'd6, 3'd6, 3'd6, 3'd6, 3'd7, 3'd7, 3'd7};
	localparam logic [1:0] HDR_SEL [HDR_LEN] = '{
		2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd2,
		2'd3, 2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd0, 2'd1, 2'd0, 2'd1,
		2'd2, 2'd3, 2'd0, 2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd0, 2'd0};

	typedef enum logic [4:0] {
		OP_NONE,
		OP_TAKE,
		OP_HDR_BYTE,
		OP_SIZE_BYTE,
		OP_AUD_BYTE,
		OP_VID_BYTE,
		OP_DISC_BYTE,
		OP_DIV1_GO,
		OP_SHARE_LD,
		OP_SUMMARY,
		OP_ERROR,
		OP_DIV2_GO,
		OP_MUL_LO,
		OP_MUL_HI,
		OP_HDR_DONE,
		OP_SZ_FIN,
		OP_CNT1,
		OP_CNT2,
		OP_AUD_ANN,
		OP_VID_ANN
	} op_t;

	typedef struct packed {
		op_t op;
		logic [2:0] status;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic div_busy;
		logic hdr_last;
		logic size_last;
		logic aud_end;
		logic vid_end;
		logic bad_zero;
		logic bad_ver;
		logic share_small;
		logic rem_zero;
		logic count_zero;
		logic vdue_zero;
	} stat_t;

endpackage
`default_nettype wire

FILE: src/avcd_div.sv
`default_nettype none
module avcd_div import avcd_pkg::*; (
	input wire clk,
	input wire arst_n,
	input wire start,
	input wire [SHW-1:0] dividend,
	input wire [SHW-1:0] divisor,
	output logic busy,
	output logic [SHW-1:0] quotient
);

	localparam int CW = $clog2(SHW + 1);

	logic [SHW-1:0] rem_q;
	logic [SHW-1:0] quo_q;
	logic [SHW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic [SHW:0] trial;
	logic [SHW:0] diff;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, quo_q[SHW-1]};
	assign diff = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CW'(SHW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[SHW]) begin
				rem_q <= diff[SHW-1:0];
			end else begin
				rem_q <= trial[SHW-1:0];
			end
			quo_q <= {quo_q[SHW-2:0], ~diff[SHW]};
		end
	end

	assign busy = busy_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

FILE: src/avcd_dp.sv
`default_nettype none
module avcd_dp import avcd_pkg::*; (
	input wire clk,
	input wire arst_n,
	input cmd_t cmd,
	output stat_t stat,
	input wire [7:0] data_byte,
	input wire out_stall,
	output logic out_valid,
	output logic [2:0] kind,
	output logic [7:0] out_byte,
	output logic stream_id,
	output logic [31:0] packet_length,
	output logic last_in_packet,
	output logic [2:0] status,
	output logic [31:0] frame_count,
	output logic [31:0] frame_period_ms,
	output logic [15:0] frame_width,
	output logic [15:0] frame_height,
	output logic [15:0] audio_rate,
	output logic [15:0] codec_extra
);

	logic [31:0] fields_q [7];
	logic [7:0] byte_q;
	logic [4:0] pos_q;
	logic [23:0] size_acc_q;
	logic wide_q;
	logic [SHW-1:0] share_q;
	logic [63:0] acc_q;
	logic [63:0] base_q;
	logic [31:0] rem_q;
	logic [31:0] count_q;
	logic [31:0] adue_q;
	logic [23:0] vdue_q;
	logic [QW+SPL-1:0] plo_q;
	logic [QW+SHW-SPL-1:0] phi_q;
	logic qzero_q;

	logic out_valid_q;
	logic [2:0] kind_q;
	logic [7:0] obyte_q;
	logic sid_q;
	logic [31:0] len_q;
	logic last_q;
	logic [2:0] st_q;

	logic div_start;
	logic [SHW-1:0] div_dividend;
	logic [SHW-1:0] div_divisor;
	logic div_busy;
	logic [SHW-1:0] div_quo;

	logic [2:0] hfield;
	logic [1:0] hsel;
	logic [QW-1:0] rate_mul;
	logic [QW-1:0] qm1;
	logic [63:0] rsum;
	logic [63-FRAC_BITS:0] rcount;
	logic [31:0] wh;
	logic emit;

	assign hfield = HDR_FIELD[pos_q];
	assign hsel = HDR_SEL[pos_q];
	assign rate_mul = QW'(fields_q[4][15:0]) * QW'(RATE_SCALE);
	assign qm1 = div_quo[QW-1:0] - 1'b1;
	assign rsum = base_q + 64'(ROUND_ADD);
	assign rcount = rsum[63:FRAC_BITS];
	assign wh = 32'(fields_q[3][15:0]) * 32'(fields_q[3][31:16]);

	assign div_start = (cmd.op == OP_DIV1_GO) || (cmd.op == OP_DIV2_GO);
	assign div_dividend = (cmd.op == OP_DIV1_GO) ? {fields_q[5], {FRAC_BITS{1'b0}}}
		: SHW'(rate_mul);
	assign div_divisor = (cmd.op == OP_DIV1_GO) ? SHW'(fields_q[1]) : share_q;

	avcd_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dividend),
		.divisor(div_divisor),
		.busy(div_busy),
		.quotient(div_quo)
	);

	assign emit = (cmd.op == OP_HDR_BYTE) || (cmd.op == OP_SIZE_BYTE) ||
		(cmd.op == OP_AUD_BYTE) || (cmd.op == OP_VID_BYTE) ||
		(cmd.op == OP_DISC_BYTE) || (cmd.op == OP_SUMMARY) ||
		(cmd.op == OP_ERROR) || (cmd.op == OP_AUD_ANN) || (cmd.op == OP_VID_ANN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_TAKE: begin
				byte_q <= data_byte;
			end
			OP_HDR_BYTE: begin
				kind_q <= K_HDR;
				obyte_q <= byte_q;
				sid_q <= 1'b0;
				len_q <= '0;
				last_q <= 1'b0;
				st_q <= ST_OK;
				if (hfield != HDR_SKIP) begin
					fields_q[hfield][8*hsel +: 8] <= byte_q;
				end
			end
			OP_SIZE_BYTE: begin
				kind_q <= K_SIZE;
				obyte_q <= byte_q;
				sid_q <= 1'b0;
				len_q <= '0;
				last_q <= 1'b0;
				st_q <= ST_OK;
				case (pos_q[1:0])
					2'd0: size_acc_q[7:0] <= byte_q;
					2'd1: size_acc_q[15:8] <= byte_q;
					default: size_acc_q[23:16] <= byte_q;
				endcase
			end
			OP_AUD_BYTE: begin
				kind_q <= K_PAY;
				obyte_q <= byte_q;
				sid_q <= 1'b0;
				len_q <= '0;
				last_q <= (adue_q <= 32'd1);
				st_q <= ST_OK;
				if (adue_q != '0) begin
					adue_q <= adue_q - 1'b1;
				end
			end
			OP_VID_BYTE: begin
				kind_q <= K_PAY;
				obyte_q <= byte_q;
				sid_q <= 1'b1;
				len_q <= '0;
				last_q <= (vdue_q <= 24'd1);
				st_q <= ST_OK;
				if (vdue_q != '0) begin
					vdue_q <= vdue_q - 1'b1;
				end
			end
			OP_DISC_BYTE: begin
				kind_q <= K_DISC;
				obyte_q <= byte_q;
				sid_q <= 1'b0;
				len_q <= '0;
				last_q <= 1'b0;
				st_q <= ST_OK;
			end
			OP_SHARE_LD: begin
				share_q <= div_quo;
			end
			OP_SUMMARY: begin
				kind_q <= K_SUM;
				obyte_q <= '0;
				sid_q <= 1'b0;
				len_q <= '0;
				last_q <= 1'b0;
				st_q <= cmd.status;
			end
			OP_ERROR: begin
				kind_q <= K_ERR;
				obyte_q <= '0;
				sid_q <= 1'b0;
				len_q <= '0;
				last_q <= 1'b0;
				st_q <= cmd.status;
			end
			OP_MUL_LO: begin
				plo_q <= (QW+SPL)'(qm1) * (QW+SPL)'(share_q[SPL-1:0]);
				qzero_q <= (div_quo == '0);
			end
			OP_MUL_HI: begin
				phi_q <= (QW+SHW-SPL)'(qm1) * (QW+SHW-SPL)'(share_q[SHW-1:SPL]);
			end
			OP_HDR_DONE: begin
				// zero quotient wraps to minus one share
				if (qzero_q) begin
					acc_q <= 64'd0 - 64'(share_q);
				end else begin
					acc_q <= 64'(plo_q) + (64'(phi_q) << SPL);
				end
				rem_q <= fields_q[5];
				wide_q <= (wh[31:16] != '0);
				size_acc_q <= '0;
			end
			OP_SZ_FIN: begin
				vdue_q <= size_acc_q;
				size_acc_q <= '0;
			end
			OP_CNT1: begin
				base_q <= acc_q + 64'(share_q);
			end
			OP_CNT2: begin
				if (rcount > (64-FRAC_BITS)'(rem_q)) begin
					count_q <= rem_q;
				end else begin
					count_q <= rcount[31:0];
				end
			end
			OP_AUD_ANN: begin
				kind_q <= K_ANN;
				obyte_q <= '0;
				sid_q <= 1'b0;
				len_q <= count_q;
				last_q <= 1'b0;
				st_q <= ST_OK;
				acc_q <= base_q - (64'(count_q) << FRAC_BITS);
				rem_q <= rem_q - count_q;
				adue_q <= count_q;
			end
			OP_VID_ANN: begin
				kind_q <= K_ANN;
				obyte_q <= '0;
				sid_q <= 1'b1;
				len_q <= 32'(vdue_q);
				last_q <= 1'b0;
				st_q <= ST_OK;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else begin
			case (cmd.op)
				OP_HDR_BYTE, OP_SIZE_BYTE: pos_q <= pos_q + 1'b1;
				OP_HDR_DONE, OP_SZ_FIN: pos_q <= '0;
				default: begin
				end
			endcase
		end
	end

	assign stat.out_free = !out_valid_q || !out_stall;
	assign stat.div_busy = div_busy;
	assign stat.hdr_last = (pos_q == 5'(HDR_LEN - 1));
	assign stat.size_last = wide_q ? (pos_q >= 5'd2) : (pos_q == 5'd1);
	assign stat.aud_end = (adue_q <= 32'd1);
	assign stat.vid_end = (vdue_q <= 24'd1);
	assign stat.bad_zero = (fields_q[1] == '0) || (fields_q[5] == '0);
	assign stat.bad_ver = (fields_q[0][7:0] != VERSION_OK) || (fields_q[6] > PLAYER_MAX);
	assign stat.share_small = (share_q <= SHARE_MIN);
	assign stat.rem_zero = (rem_q == '0);
	assign stat.count_zero = (count_q == '0);
	assign stat.vdue_zero = (vdue_q == '0);

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign out_byte = obyte_q;
	assign stream_id = sid_q;
	assign packet_length = len_q;
	assign last_in_packet = last_q;
	assign status = st_q;
	assign frame_count = (kind_q == K_SUM) ? fields_q[1] : '0;
	assign frame_period_ms = (kind_q == K_SUM) ? fields_q[2] : '0;
	assign frame_width = (kind_q == K_SUM) ? fields_q[3][15:0] : '0;
	assign frame_height = (kind_q == K_SUM) ? fields_q[3][31:16] : '0;
	assign audio_rate = (kind_q == K_SUM) ? fields_q[4][15:0] : '0;
	assign codec_extra = (kind_q == K_SUM) ? fields_q[0][23:8] : '0;

endmodule
`default_nettype wire

FILE: src/avcd_ctrl.sv
`default_nettype none
module avcd_ctrl import avcd_pkg::*; (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	output logic in_stall,
	input stat_t stat,
	output cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE, S_BYTE, S_HCHK, S_DIV1, S_SHCHK, S_SUM, S_ERR, S_D2GO, S_DIV2,
		S_MLO, S_MHI, S_HFIN, S_SZFIN, S_CNT1, S_CNT2, S_AANN, S_VSTART
	} state_t;

	typedef enum logic [2:0] {
		PH_HEADER, PH_SIZE, PH_AUDIO, PH_VIDEO, PH_DEAD
	} phase_t;

	state_t state_q, state_d;
	phase_t phase_q, phase_d;
	logic [2:0] st_q, st_d;

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		st_d = st_q;
		cmd.op = OP_NONE;
		cmd.status = st_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = OP_TAKE;
					state_d = S_BYTE;
				end
			end
			S_BYTE: begin
				if (stat.out_free) begin
					state_d = S_IDLE;
					case (phase_q)
						PH_HEADER: begin
							cmd.op = OP_HDR_BYTE;
							if (stat.hdr_last) state_d = S_HCHK;
						end
						PH_SIZE: begin
							cmd.op = OP_SIZE_BYTE;
							if (stat.size_last) state_d = S_SZFIN;
						end
						PH_AUDIO: begin
							cmd.op = OP_AUD_BYTE;
							if (stat.aud_end) state_d = S_VSTART;
						end
						PH_VIDEO: begin
							cmd.op = OP_VID_BYTE;
							if (stat.vid_end) phase_d = PH_SIZE;
						end
						default: begin
							cmd.op = OP_DISC_BYTE;
						end
					endcase
				end
			end
			S_HCHK: begin
				if (stat.bad_zero) begin
					st_d = ST_ZERO;
					state_d = S_SUM;
				end else if (stat.bad_ver) begin
					st_d = ST_VERSION;
					state_d = S_SUM;
				end else begin
					cmd.op = OP_DIV1_GO;
					state_d = S_DIV1;
				end
			end
			S_DIV1: begin
				if (!stat.div_busy) begin
					cmd.op = OP_SHARE_LD;
					state_d = S_SHCHK;
				end
			end
			S_SHCHK: begin
				st_d = stat.share_small ? ST_SHARE : ST_OK;
				state_d = S_SUM;
			end
			S_SUM: begin
				if (stat.out_free) begin
					cmd.op = OP_SUMMARY;
					state_d = (st_q != ST_OK) ? S_ERR : S_D2GO;
				end
			end
			S_ERR: begin
				if (stat.out_free) begin
					cmd.op = OP_ERROR;
					phase_d = PH_DEAD;
					state_d = S_IDLE;
				end
			end
			S_D2GO: begin
				cmd.op = OP_DIV2_GO;
				state_d = S_DIV2;
			end
			S_DIV2: begin
				if (!stat.div_busy) state_d = S_MLO;
			end
			S_MLO: begin
				cmd.op = OP_MUL_LO;
				state_d = S_MHI;
			end
			S_MHI: begin
				cmd.op = OP_MUL_HI;
				state_d = S_HFIN;
			end
			S_HFIN: begin
				cmd.op = OP_HDR_DONE;
				phase_d = PH_SIZE;
				state_d = S_IDLE;
			end
			S_SZFIN: begin
				cmd.op = OP_SZ_FIN;
				if (stat.rem_zero) begin
					st_d = ST_EXHAUST;
					state_d = S_ERR;
				end else begin
					state_d = S_CNT1;
				end
			end
			S_CNT1: begin
				cmd.op = OP_CNT1;
				state_d = S_CNT2;
			end
			S_CNT2: begin
				cmd.op = OP_CNT2;
				state_d = S_AANN;
			end
			S_AANN: begin
				if (stat.out_free) begin
					cmd.op = OP_AUD_ANN;
					if (stat.count_zero) begin
						state_d = S_VSTART;
					end else begin
						phase_d = PH_AUDIO;
						state_d = S_IDLE;
					end
				end
			end
			S_VSTART: begin
				// empty video goes straight back to the length bytes
				if (stat.vdue_zero) begin
					phase_d = PH_SIZE;
					state_d = S_IDLE;
				end else if (stat.out_free) begin
					cmd.op = OP_VID_ANN;
					phase_d = PH_VIDEO;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_HEADER;
			st_q <= ST_OK;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			st_q <= st_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule
`default_nettype wire

FILE: src/audio_video_chunk_deframer.sv
`default_nettype none
// channel  direction  handshake          fields
// in       input      in_valid/in_stall    data_byte
// out      output     out_valid/out_stall  kind .. codec_extra
//
// each item is taken and then emitted as a result when out is not stalled; the byte
// ending a video length adds the accumulator steps (only the size-finish step when
// audio is exhausted), and an empty video packet skipped after the audio adds a check state.
// the last header byte runs two serial divisions on the shared divider plus a two-step
// split multiply; a header that fails the early checks skips them.
// reset clears the control and returns the block to the header.
// a stalled output holds its result; the input stalls until the item is done.
module audio_video_chunk_deframer import avcd_pkg::*; (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	output logic in_stall,
	input wire [7:0] data_byte,
	output logic out_valid,
	input wire out_stall,
	output logic [2:0] kind,
	output logic [7:0] out_byte,
	output logic stream_id,
	output logic [31:0] packet_length,
	output logic last_in_packet,
	output logic [2:0] status,
	output logic [31:0] frame_count,
	output logic [31:0] frame_period_ms,
	output logic [15:0] frame_width,
	output logic [15:0] frame_height,
	output logic [15:0] audio_rate,
	output logic [15:0] codec_extra
);

	cmd_t cmd;
	stat_t stat;

	avcd_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.stat(stat),
		.cmd(cmd)
	);

	avcd_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.data_byte(data_byte),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.kind(kind),
		.out_byte(out_byte),
		.stream_id(stream_id),
		.packet_length(packet_length),
		.last_in_packet(last_in_packet),
		.status(status),
		.frame_count(frame_count),
		.frame_period_ms(frame_period_ms),
		.frame_width(frame_width),
		.frame_height(frame_height),
		.audio_rate(audio_rate),
		.codec_extra(codec_extra)
	);

endmodule
`default_nettype wire
